>>> rtl/gsc_pkg.sv
// Shared types, constants and helpers for the gas state completion pipeline.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package gsc_pkg;

  // Number of momentum axes that enter the kinetic energy.
  localparam int DIMS_DEFAULT = 3;

  // Configuration register width and reset values, unsigned Q2.16.
  localparam int CFG_W = 18;
  localparam logic [CFG_W-1:0] GAMMA_RESET = 18'd91750;
  localparam logic [CFG_W-1:0] GM1_RESET   = 18'd26214;

  // Configuration register indexes.
  typedef enum logic {
    REG_GAMMA = 1'b0,
    REG_GM1   = 1'b1
  } cfg_reg_t;

  // Pipeline step counts: kinetic divide, sound divide, square root.
  localparam int KE_STEPS = 64;
  localparam int SD_STEPS = 62;
  localparam int SQ_STEPS = 31;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;

  // Conserved state of one cell as it travels down the pipeline.
  typedef struct packed {
    logic        ok;
    logic [31:0] rho;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [31:0] energy;
  } cell_t;

  // Cell plus pressure and fault flag.
  typedef struct packed {
    cell_t       c;
    logic [31:0] p;
    logic        fault;
  } prim_t;

  // Complete result beat.
  typedef struct packed {
    prim_t       pr;
    logic [30:0] sound;
  } res_t;

  // Magnitude of a signed 32-bit value as an unsigned 32-bit value.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

endpackage

>>> rtl/gsc_kin.sv
// Kinetic energy stage: squares the momenta and divides by twice the density.
// Depends on gsc_pkg; one restoring divide step per pipeline stage.
module gsc_kin (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  gsc_pkg::cell_t in_c,
  output logic           out_v,
  output gsc_pkg::cell_t out_c,
  output logic [63:0]    ke
);

  localparam int N = gsc_pkg::KE_STEPS;

  typedef struct packed {
    gsc_pkg::cell_t c;
    logic [31:0]    rem;
    logic [63:0]    dq;
  } kd_t;

  logic           va;
  logic           vb;
  gsc_pkg::cell_t ca;
  gsc_pkg::cell_t cb;
  logic [31:0]    m0;
  logic [31:0]    m1;
  logic [31:0]    m2;
  logic [63:0]    sq0;
  logic [63:0]    sq1;
  logic [63:0]    sq2;
  logic [63:0]    sum;
  logic [N-1:0]   kv;
  kd_t            kq [N];
  kd_t            kn [N];
  kd_t            first;

  assign m0 = gsc_pkg::mag32(in_c.mx);
  assign m1 = gsc_pkg::mag32(in_c.my);
  assign m2 = gsc_pkg::mag32(in_c.mz);

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      kv <= '0;
    end else if (en) begin
      va <= in_v;
      vb <= va;
      kv <= {kv[N-2:0], vb};
    end
  end

  // Squares in the first stage, their sum in the second.
  always_ff @(posedge clk) begin
    if (en) begin
      ca  <= in_c;
      sq0 <= 64'(m0) * 64'(m0);
      sq1 <= 64'(m1) * 64'(m1);
      sq2 <= 64'(m2) * 64'(m2);
      cb  <= ca;
      sum <= sq0 + sq1 + sq2;
    end
  end

  assign first = '{c: cb, rem: 32'd0, dq: sum};

  // One quotient bit per stage; the divisor is twice the density.
  always_comb begin
    kd_t         s;
    logic [32:0] t;
    logic [32:0] dd;
    logic        ge;
    for (int i = 0; i < N; i++) begin
      s  = (i == 0) ? first : kq[(i == 0) ? 0 : i - 1];
      t  = {s.rem, s.dq[63]};
      dd = {1'b0, s.c.rho[30:0], 1'b0};
      ge = (t >= dd);
      kn[i].c   = s.c;
      kn[i].rem = ge ? 32'(t - dd) : t[31:0];
      kn[i].dq  = {s.dq[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        kq[i] <= kn[i];
      end
    end
  end

  assign out_v = kv[N-1];
  assign out_c = kq[N-1].c;
  assign ke    = kq[N-1].dq;

endmodule

>>> rtl/gsc_pres.sv
// Pressure stage: internal energy times gamma minus one, truncated and saturated.
// Depends on gsc_pkg; three register stages.
module gsc_pres (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [gsc_pkg::CFG_W-1:0] gm1,
  input  logic                      in_v,
  input  gsc_pkg::cell_t            in_c,
  input  logic [63:0]               in_ke,
  output logic                      out_v,
  output gsc_pkg::prim_t            out_pr
);

  logic [65:0]    e_int;
  logic [65:0]    e_mag;
  logic           v1;
  logic           v2;
  gsc_pkg::cell_t c1;
  gsc_pkg::cell_t c2;
  logic           neg1;
  logic           neg2;
  logic [63:0]    mag1;
  logic           big2;
  logic [49:0]    ph_w;
  logic [33:0]    pl_w;
  logic [49:0]    ph2;
  logic [33:0]    pl2;
  logic [50:0]    prod;
  logic [31:0]    p_next;

  assign e_int = {{34{in_c.energy[31]}}, in_c.energy} - {2'b00, in_ke};
  assign e_mag = e_int[65] ? 66'(~e_int + 66'd1) : e_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      out_v <= v2;
    end
  end

  // Split product: upper magnitude bits and low fraction bits separately.
  assign ph_w = 50'(mag1[47:16]) * 50'(gm1);
  assign pl_w = 34'(mag1[15:0]) * 34'(gm1);

  // Combine, apply the sign and saturate to the signed 32-bit range.
  assign prod = {1'b0, ph2} + {17'd0, pl2[33:16]};

  always_comb begin
    if (big2) begin
      p_next = neg2 ? gsc_pkg::S32_MIN : gsc_pkg::S32_MAX;
    end else if (neg2) begin
      p_next = (prod >= 51'h8000_0000) ? gsc_pkg::S32_MIN : 32'(~prod[31:0] + 32'd1);
    end else begin
      p_next = (prod > 51'h7FFF_FFFF) ? gsc_pkg::S32_MAX : prod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1           <= in_c;
      neg1         <= e_int[65];
      mag1         <= e_mag[63:0];
      c2           <= c1;
      neg2         <= neg1;
      big2         <= (|mag1[63:48]) && (gm1 != '0);
      ph2          <= ph_w;
      pl2          <= pl_w;
      out_pr.c     <= c2;
      out_pr.p     <= p_next;
      out_pr.fault <= ($signed(p_next) <= 32'sd0);
    end
  end

endmodule

>>> rtl/gsc_sound.sv
// Sound speed stage: gamma*p, a pipelined divide by density, then a pipelined
// square root. Depends on gsc_pkg. Also zeroes the whole result of invalid cells.
module gsc_sound (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [gsc_pkg::CFG_W-1:0] gamma,
  input  logic                      in_v,
  input  gsc_pkg::prim_t            in_pr,
  output logic                      out_v,
  output gsc_pkg::res_t             out_res
);

  localparam int ND = gsc_pkg::SD_STEPS;
  localparam int NQ = gsc_pkg::SQ_STEPS;

  typedef struct packed {
    gsc_pkg::prim_t pr;
    logic           sat;
    logic [30:0]    rem;
    logic [61:0]    dq;
  } ds_t;

  typedef struct packed {
    gsc_pkg::prim_t pr;
    logic           sat;
    logic [32:0]    r;
    logic [30:0]    q;
    logic [61:0]    x;
  } sq_t;

  logic           v1;
  gsc_pkg::prim_t pr1;
  logic [48:0]    num1;
  logic [ND-1:0]  dv;
  ds_t            dsq [ND];
  ds_t            dsn [ND];
  ds_t            dfirst;
  logic [NQ-1:0]  qv;
  sq_t            sqq [NQ];
  sq_t            sqn [NQ];
  sq_t            qfirst;
  sq_t            last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      dv <= '0;
      qv <= '0;
    end else if (en) begin
      v1 <= in_v;
      dv <= {dv[ND-2:0], v1};
      qv <= {qv[NQ-2:0], dv[ND-1]};
    end
  end

  // Numerator gamma times pressure; only positive pressure is used.
  always_ff @(posedge clk) begin
    if (en) begin
      pr1  <= in_pr;
      num1 <= 49'(gamma) * 49'(in_pr.p[30:0]);
    end
  end

  // The quotient saturates when num >= rho * 2^46.
  assign dfirst = '{pr: pr1,
                    sat: ({29'd0, num1[48:46]} >= pr1.c.rho),
                    rem: {28'd0, num1[48:46]},
                    dq: {num1[45:0], 16'd0}};

  // Divide num * 2^16 by the density, one quotient bit per stage.
  always_comb begin
    ds_t         s;
    logic [31:0] t;
    logic        ge;
    for (int i = 0; i < ND; i++) begin
      s  = (i == 0) ? dfirst : dsq[(i == 0) ? 0 : i - 1];
      t  = {s.rem, s.dq[61]};
      ge = (t >= s.pr.c.rho);
      dsn[i].pr  = s.pr;
      dsn[i].sat = s.sat;
      dsn[i].rem = ge ? 31'(t - s.pr.c.rho) : t[30:0];
      dsn[i].dq  = {s.dq[60:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ND; i++) begin
        dsq[i] <= dsn[i];
      end
    end
  end

  assign qfirst = '{pr: dsq[ND-1].pr, sat: dsq[ND-1].sat, r: 33'd0, q: 31'd0,
                    x: dsq[ND-1].dq};

  // Restoring square root, one root bit per stage.
  always_comb begin
    sq_t         s;
    logic [34:0] rr;
    logic [34:0] trial;
    logic        ge;
    for (int i = 0; i < NQ; i++) begin
      s     = (i == 0) ? qfirst : sqq[(i == 0) ? 0 : i - 1];
      rr    = {s.r, s.x[61:60]};
      trial = {2'b00, s.q, 2'b01};
      ge    = (rr >= trial);
      sqn[i].pr  = s.pr;
      sqn[i].sat = s.sat;
      sqn[i].r   = ge ? 33'(rr - trial) : rr[32:0];
      sqn[i].q   = {s.q[29:0], ge};
      sqn[i].x   = {s.x[59:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NQ; i++) begin
        sqq[i] <= sqn[i];
      end
    end
  end

  // Final selection: invalid cells are all zero, faults give no sound speed.
  assign last  = sqq[NQ-1];
  assign out_v = qv[NQ-1];

  always_comb begin
    out_res = '0;
    if (last.pr.c.ok) begin
      out_res.pr = last.pr;
      if (last.pr.fault) begin
        out_res.sound = '0;
      end else if (last.sat) begin
        out_res.sound = gsc_pkg::U31_MAX;
      end else begin
        out_res.sound = last.q;
      end
    end
  end

endmodule

>>> rtl/gsc_obuf.sv
// Two-entry output buffer that decouples the pipeline from the consumer.
// Depends on gsc_pkg; the pipeline advances while an entry is free.
module gsc_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_v,
  input  gsc_pkg::res_t in_res,
  output logic          en,
  output logic          out_v,
  input  logic          out_rdy,
  output gsc_pkg::res_t out_res
);

  gsc_pkg::res_t mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign en      = (cnt != 2'd2);
  assign push    = en && in_v;
  assign out_v   = (cnt != 2'd0);
  assign pop     = out_v && out_rdy;
  assign out_res = mem[rp];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_res;
    end
  end

endmodule

>>> rtl/gas_state_completion.sv
// Top level of the ideal gas conservative-to-primitive completion pipeline.
// Depends on gsc_pkg, gsc_kin, gsc_pres, gsc_sound and gsc_obuf.
//
//   Channel   Signals                         Beat
//   input     in_valid / in_ready             one cell's conserved state
//   output    out_valid / out_ready           one cell's primitive result
//   config    cfg_we, cfg_index, cfg_data     one register write, no wait
//
// One cell enters per cycle while in_ready is high; out_valid rises after the
// 64 kinetic divide stages, 62 sound divide stages and 31 square root stages,
// plus the square, pressure, numerator and output buffer registers.
// Reset clears all valid bits and loads gamma 1.4 and gamma minus one 0.4.
// When the output stalls, the two-entry output buffer fills and then the whole
// pipeline holds; in_ready falls only when both entries are taken.
module gas_state_completion #(
  parameter int DIMENSIONS = gsc_pkg::DIMS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mask_in,
  input  logic signed [31:0]        density,
  input  logic signed [31:0]        momentum_x,
  input  logic signed [31:0]        momentum_y,
  input  logic signed [31:0]        momentum_z,
  input  logic signed [31:0]        total_energy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      valid_out,
  output logic signed [31:0]        density_out,
  output logic signed [31:0]        momentum_x_out,
  output logic signed [31:0]        momentum_y_out,
  output logic signed [31:0]        momentum_z_out,
  output logic signed [31:0]        energy_out,
  output logic signed [31:0]        pressure,
  output logic [30:0]               sound_speed,
  output logic                      pressure_fault,
  input  logic                      cfg_we,
  input  gsc_pkg::cfg_reg_t         cfg_index,
  input  logic [gsc_pkg::CFG_W-1:0] cfg_data
);

  logic [gsc_pkg::CFG_W-1:0] gamma;
  logic [gsc_pkg::CFG_W-1:0] gm1;
  logic                      en;
  gsc_pkg::cell_t            in_c;
  logic                      kin_v;
  gsc_pkg::cell_t            kin_c;
  logic [63:0]               kin_ke;
  logic                      pres_v;
  gsc_pkg::prim_t            pres_pr;
  logic                      snd_v;
  gsc_pkg::res_t             snd_res;
  gsc_pkg::res_t             ob_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= gsc_pkg::GAMMA_RESET;
      gm1   <= gsc_pkg::GM1_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsc_pkg::REG_GAMMA: gamma <= cfg_data;
        gsc_pkg::REG_GM1:   gm1   <= cfg_data;
        default:            gamma <= gamma;
      endcase
    end
  end

  // Cell qualification; unused axes are dropped here.
  always_comb begin
    in_c.ok     = mask_in && !density[31] && (density != 32'sd0);
    in_c.rho    = density;
    in_c.mx     = momentum_x;
    in_c.my     = (DIMENSIONS >= 2) ? momentum_y : 32'd0;
    in_c.mz     = (DIMENSIONS >= 3) ? momentum_z : 32'd0;
    in_c.energy = total_energy;
  end

  assign in_ready = en;

  gsc_kin u_kin (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (in_valid),
    .in_c  (in_c),
    .out_v (kin_v),
    .out_c (kin_c),
    .ke    (kin_ke)
  );

  gsc_pres u_pres (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .gm1    (gm1),
    .in_v   (kin_v),
    .in_c   (kin_c),
    .in_ke  (kin_ke),
    .out_v  (pres_v),
    .out_pr (pres_pr)
  );

  gsc_sound u_sound (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .gamma   (gamma),
    .in_v    (pres_v),
    .in_pr   (pres_pr),
    .out_v   (snd_v),
    .out_res (snd_res)
  );

  gsc_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .in_v    (snd_v),
    .in_res  (snd_res),
    .en      (en),
    .out_v   (out_valid),
    .out_rdy (out_ready),
    .out_res (ob_res)
  );

  // Result fields.
  assign valid_out      = ob_res.pr.c.ok;
  assign density_out    = ob_res.pr.c.rho;
  assign momentum_x_out = ob_res.pr.c.mx;
  assign momentum_y_out = ob_res.pr.c.my;
  assign momentum_z_out = ob_res.pr.c.mz;
  assign energy_out     = ob_res.pr.c.energy;
  assign pressure       = ob_res.pr.p;
  assign sound_speed    = ob_res.sound;
  assign pressure_fault = ob_res.pr.fault;

`ifndef ASSERT_OFF
  a_fault_no_sound: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_fault |-> sound_speed == 31'd0)
    else $error("sound speed nonzero on a pressure fault");

  a_fault_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_fault |-> valid_out)
    else $error("pressure fault on an invalid cell");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_out |-> pressure == 32'sd0 && density_out == 32'sd0 &&
    sound_speed == 31'd0)
    else $error("invalid cell with nonzero result");
`endif

endmodule

>>> verif/gas_state_completion_tb.sv
// Self-checking testbench for gas_state_completion: directed and random cells,
// predicted pressure and sound speed compared beat by beat with the DUT output.
// Depends on gsc_pkg and the gas_state_completion RTL.
module gas_state_completion_tb;
  import gsc_pkg::*;

  localparam int LATENCY = 200;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic        mask;
    logic [31:0] rho, mx, my, mz, en;
  } cell_in_t;

  typedef struct {
    logic        ok;
    logic [31:0] rho, mx, my, mz, en, p;
    logic [30:0] snd;
    logic        fault;
  } cell_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mask_in = 1'b0;
  logic signed [31:0] density = '0, momentum_x = '0, momentum_y = '0;
  logic signed [31:0] momentum_z = '0, total_energy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic valid_out, pressure_fault;
  logic signed [31:0] density_out, momentum_x_out, momentum_y_out, momentum_z_out;
  logic signed [31:0] energy_out, pressure;
  logic [30:0] sound_speed;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_GAMMA;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predictor copy of the configuration registers.
  logic [CFG_W-1:0] gamma_q = GAMMA_RESET;
  logic [CFG_W-1:0] gm1_q = GM1_RESET;

  cell_in_t pending_cells[$];
  cell_out_t expected_prims[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_off = 0;
  bit done = 0;

  gas_state_completion u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-serial integer square root, floored.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res, bit_q;
    res = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > x) bit_q >>= 2;
    while (bit_q != 0) begin
      if (x >= res + bit_q) begin
        x = x - (res + bit_q);
        res = (res >> 1) + bit_q;
      end else begin
        res >>= 1;
      end
      bit_q >>= 2;
    end
    return res;
  endfunction

  // Primitive variables of one cell under the current gamma settings.
  function automatic cell_out_t complete_cell(input cell_in_t c);
    cell_out_t r;
    logic signed [63:0] rho, en, e_int, p;
    logic [63:0] sum, ke, mag, hi, lo, prod, num, q, rem, t, s;
    r = '{default: '0};
    rho = 64'(signed'(c.rho));
    en = 64'(signed'(c.en));
    if (!c.mask || rho <= 0) return r;
    sum = 0;
    mag = 64'(mag32(c.mx)); sum += mag * mag;
    mag = 64'(mag32(c.my)); sum += mag * mag;
    mag = 64'(mag32(c.mz)); sum += mag * mag;
    ke = sum / (64'd2 * 64'(rho));
    e_int = en - signed'(ke);
    // Pressure: magnitude scaled, truncated toward zero, then saturated.
    if (gm1_q == 0 || e_int == 0) begin
      p = 0;
    end else begin
      mag = e_int < 0 ? 64'(-e_int) : 64'(e_int);
      hi = mag >> 16;
      lo = mag & 64'hFFFF;
      if (hi >= (64'd1 << 32)) begin
        p = e_int < 0 ? -64'sh80000000 : 64'sh7FFFFFFF;
      end else begin
        prod = hi * gm1_q + ((lo * gm1_q) >> 16);
        if (e_int < 0) p = prod >= 64'h80000000 ? -64'sh80000000 : -signed'(prod);
        else p = prod > 64'h7FFFFFFF ? 64'sh7FFFFFFF : signed'(prod);
      end
    end
    s = 0;
    if (p <= 0) begin
      r.fault = 1'b1;
    end else begin
      num = 64'(gamma_q) * 64'(p);
      q = num / 64'(rho);
      rem = num % 64'(rho);
      if (q >= (64'd1 << 46)) begin
        s = 64'h7FFFFFFF;
      end else begin
        t = (q << 16) + ((rem << 16) / 64'(rho));
        s = floor_sqrt(t);
        if (s > 64'h7FFFFFFF) s = 64'h7FFFFFFF;
      end
    end
    r.ok = 1'b1;
    r.rho = c.rho; r.mx = c.mx; r.my = c.my; r.mz = c.mz; r.en = c.en;
    r.p = p[31:0];
    r.snd = s[30:0];
    return r;
  endfunction

  // Driver: offers queued cells, idling at random between beats.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cell_in_t c;
          c = pending_cells.pop_front();
          expected_prims.push_back(complete_cell(c));
          in_valid <= 1'b1;
          mask_in <= c.mask;
          density <= c.rho;
          momentum_x <= c.mx;
          momentum_y <= c.my;
          momentum_z <= c.mz;
          total_energy <= c.en;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_prims.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, pressure %h", pressure);
      end else begin
        cell_out_t e;
        e = expected_prims.pop_front();
        if (valid_out !== e.ok || density_out !== e.rho || momentum_x_out !== e.mx ||
            momentum_y_out !== e.my || momentum_z_out !== e.mz ||
            energy_out !== e.en || pressure !== e.p || sound_speed !== e.snd ||
            pressure_fault !== e.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp ok%b %h %h %h %h %h p%h c%h f%b",
                      " got ok%b %h %h %h %h %h p%h c%h f%b"},
                     e.ok, e.rho, e.mx, e.my, e.mz, e.en, e.p, e.snd, e.fault,
                     valid_out, density_out, momentum_x_out, momentum_y_out,
                     momentum_z_out, energy_out, pressure, sound_speed, pressure_fault);
        end
      end
    end
  end

  // Watchdog: counts cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gas_state_completion_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(65536 * 4)) - 32'd131072;
      3: return 32'($urandom_range(65536 * 64));
      default: return $urandom();
    endcase
  endfunction

  // A mostly physical cell: positive density, modest momentum, non-negative energy.
  function automatic cell_in_t rand_cell();
    cell_in_t c;
    c.mask = $urandom_range(15) != 0;
    if ($urandom_range(3) == 0) begin
      c.rho = rand_field(); c.mx = rand_field(); c.my = rand_field();
      c.mz = rand_field(); c.en = rand_field();
    end else begin
      c.rho = 32'($urandom_range(32'h7FFF_FFFF, 1)) >> $urandom_range(30);
      if (c.rho == 0) c.rho = 1;
      c.mx = $urandom() >>> $urandom_range(31, 8);
      c.my = $urandom() >>> $urandom_range(31, 8);
      c.mz = $urandom() >>> $urandom_range(31, 8);
      c.en = $urandom() >> $urandom_range(20, 1);
    end
    return c;
  endfunction

  task automatic add_cell(input logic m, input logic [31:0] r, x, y, z, e);
    pending_cells.push_back('{m, r, x, y, z, e});
  endtask

  task automatic drain();
    wait (pending_cells.size() == 0 && expected_prims.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_GAMMA) gamma_q = val; else gm1_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    repeat (n) pending_cells.push_back(rand_cell());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 74;

    // Directed: masked, nonpositive density, extremes, fault, saturation.
    add_cell(0, 32'h0001_0000, 32'h1, 32'h2, 32'h3, 32'h4);
    add_cell(1, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4);
    add_cell(1, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    add_cell(1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    add_cell(1, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    add_cell(1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    add_cell(1, 32'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_cell(1, 32'h1, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
    add_cell(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF);
    add_cell(1, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0005_0000);
    add_cell(1, 32'hFFFF_FFFF, 32'h5, 32'h5, 32'h5, 32'h5);
    drain();

    // Long receiver hold-off so the pipeline backs up to the input.
    hold_off = 400;
    random_phase(300);

    // Extreme register settings.
    write_reg(REG_GAMMA, 18'h3FFFF);
    write_reg(REG_GM1, 18'h3FFFF);
    random_phase(150);
    write_reg(REG_GAMMA, 18'd0);
    write_reg(REG_GM1, 18'd0);
    random_phase(100);

    send_idle_pct = 74;
    recv_idle_pct = 8;
    write_reg(REG_GAMMA, 18'd65536);
    write_reg(REG_GM1, 18'd131072);
    random_phase(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_GAMMA, 18'd196608);
    write_reg(REG_GM1, 18'd1);
    random_phase(200);
    write_reg(REG_GAMMA, GAMMA_RESET);
    write_reg(REG_GM1, GM1_RESET);
    random_phase(250);

    done = 1;
    if (mismatches == 0 && expected_prims.size() == 0)
      $display("gas_state_completion_tb OK");
    else
      $display("gas_state_completion_tb NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/gsc_pkg.sv
rtl/gsc_kin.sv
rtl/gsc_pres.sv
rtl/gsc_sound.sv
rtl/gsc_obuf.sv
rtl/gas_state_completion.sv
verif/gas_state_completion_tb.sv
